/* hdl/grc_pkg.sv */
// Shared constants and types for the graph reachability checker.
package grc_pkg;

  localparam int unsigned MaxVertices = 32;
  localparam int unsigned VtxW        = $clog2(MaxVertices);
  localparam int unsigned DepthW      = $clog2(MaxVertices + 1);
  localparam int unsigned RowW        = 32;
  localparam int unsigned CountW      = 6;

  localparam logic OpWriteRow = 1'b0;
  localparam logic OpQuery    = 1'b1;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StFirst  = 6'b000010,
    StPush   = 6'b000100,
    StPop    = 6'b001000,
    StRow    = 6'b010000,
    StFinish = 6'b100000
  } state_e;

endpackage

/* hdl/graph_reachability_check.sv */
// Graph reachability checker: adjacency row store and depth-first query engine.
//
// Input channel (in_valid_i/in_ready_o) moves one item per transfer. A row
// write stores row_bits_i at row_index_i and leaves the input ready; it gives no
// result. A query walks the graph from start_vertex_i and gives one result
// on the output channel (out_valid_o/out_ready_i): the out-degree of the
// start vertex over the vertices in use and whether all of them were reached.
// A query whose start vertex is not below vertex_count is dropped.
// A query steps through StFirst, StPush, StPop, StRow and StFinish: each
// reached vertex beyond the start costs one push into the stack memory, and
// its pop costs an empty push check, a stack read and a row read through the
// registered adjacency memory port. One query runs at a time; a row write may
// transfer while a result waits for the receiver.
// When the receiver stalls, the finished query holds until the output
// register frees, then the block accepts again.
// Reset clears the controller and the result valid flag and sets vertex_count
// to 32; the adjacency rows hold no value until written. The user must write
// vertex_count (cfg_we_i/cfg_wdata_i) only while idle, unchecked by the block.
module graph_reachability_check
  import grc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [VtxW-1:0]   row_index_i,
  input  logic [RowW-1:0]   row_bits_i,
  input  logic [VtxW-1:0]   start_vertex_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CountW-1:0] out_degree_o,
  output logic              all_reached_o,
  output logic              bad_start_o
);

  logic [RowW-1:0] adj_mem [MaxVertices];
  logic [VtxW-1:0] stack_mem [MaxVertices];

  state_e state_q, state_d;
  logic [CountW-1:0] vcount_q;
  logic [RowW-1:0] visited_q, visited_d;
  logic [RowW-1:0] fresh_q, fresh_d;
  logic [RowW-1:0] mask_q, mask_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [CountW-1:0] deg_q, deg_d;
  logic first_q, first_d;
  logic [VtxW-1:0] start_q, start_d;

  logic out_valid_q;
  logic [CountW-1:0] out_degree_q;
  logic out_all_q;
  logic load_out;

  logic [RowW-1:0] adj_rdata_q;
  logic [VtxW-1:0] stack_rdata_q;
  logic [VtxW-1:0] adj_raddr;
  logic [VtxW-1:0] stack_raddr;
  logic stack_we;
  logic [VtxW-1:0] low_idx;
  logic [RowW-1:0] fresh_row;
  logic [CountW-1:0] n_use;
  logic [RowW-1:0] mask_new;
  logic in_xfer;

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    n_use = (vcount_q > CountW'(MaxVertices)) ? CountW'(MaxVertices) : vcount_q;
    for (int i = 0; i < RowW; i++) begin
      mask_new[i] = (CountW'(i) < n_use);
    end
  end

  always_comb begin
    low_idx = '0;
    for (int i = RowW - 1; i >= 0; i--) begin
      if (fresh_q[i]) begin
        low_idx = VtxW'(i);
      end
    end
  end

  assign fresh_row = adj_rdata_q & mask_q & ~visited_q;

  always_comb begin
    state_d     = state_q;
    visited_d   = visited_q;
    fresh_d     = fresh_q;
    mask_d      = mask_q;
    depth_d     = depth_q;
    deg_d       = deg_q;
    first_d     = first_q;
    start_d     = start_q;
    adj_raddr   = stack_rdata_q;
    stack_raddr = VtxW'(depth_q - DepthW'(1));
    stack_we    = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      StIdle: begin
        adj_raddr = start_vertex_i;
        if (in_xfer && operation_i == OpQuery &&
            CountW'(start_vertex_i) < n_use) begin
          visited_d = RowW'(1) << start_vertex_i;
          mask_d    = mask_new;
          start_d   = start_vertex_i;
          depth_d   = '0;
          first_d   = 1'b1;
          state_d   = StFirst;
        end
      end
      StFirst: begin
        deg_d     = CountW'(adj_rdata_q[start_q]);
        fresh_d   = fresh_row;
        visited_d = visited_q | fresh_row;
        state_d   = StPush;
      end
      StPush: begin
        if (fresh_q != '0) begin
          stack_we = 1'b1;
          fresh_d  = fresh_q & ~(RowW'(1) << low_idx);
          depth_d  = depth_q + DepthW'(1);
          if (first_q) begin
            deg_d = deg_q + CountW'(1);
          end
        end else if (depth_q == '0) begin
          state_d = StFinish;
        end else begin
          depth_d = depth_q - DepthW'(1);
          first_d = 1'b0;
          state_d = StPop;
        end
      end
      StPop: begin
        state_d = StRow;
      end
      StRow: begin
        fresh_d   = fresh_row;
        visited_d = visited_q | fresh_row;
        state_d   = StPush;
      end
      StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && operation_i == OpWriteRow) begin
      adj_mem[row_index_i] <= row_bits_i;
    end
    adj_rdata_q <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[depth_q[VtxW-1:0]] <= low_idx;
    end
    stack_rdata_q <= stack_mem[stack_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      vcount_q    <= CountW'(MaxVertices);
      out_valid_q <= 1'b0;
      depth_q     <= '0;
      first_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      first_q <= first_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    visited_q <= visited_d;
    fresh_q   <= fresh_d;
    mask_q    <= mask_d;
    deg_q     <= deg_d;
    start_q   <= start_d;
    if (load_out) begin
      out_degree_q <= deg_q;
      out_all_q    <= ((visited_q & mask_q) == mask_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_degree_o  = out_degree_q;
  assign all_reached_o = out_all_q;
  assign bad_start_o   = 1'b0;

endmodule

/* hdl/grc_checker.sv */
// Port-level checks for the graph reachability checker and their bind.
module grc_checker
  import grc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              operation_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [CountW-1:0] out_degree_o,
  input logic              bad_start_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_degree_o))
    else $error("result dropped or changed while stalled");

  a_write_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i == OpWriteRow |=> in_ready_o)
    else $error("row write stalled the input");

  a_degree_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_degree_o <= CountW'(MaxVertices))
    else $error("out-degree beyond vertex limit");

  a_no_bad_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !bad_start_o)
    else $error("result with bad start flag");

endmodule

bind graph_reachability_check grc_checker u_grc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .operation_i  (operation_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_degree_o (out_degree_o),
  .bad_start_o  (bad_start_o)
);
